FILE: hdl/tts_pkg.sv
package tts_pkg;

  localparam int MAX_JETS    = 16;
  localparam int CNT_W       = $clog2(MAX_JETS + 1);
  localparam int IDX_W       = 5;
  localparam int ETA_W       = 16;
  localparam int PHI_W       = 15;
  localparam int SCORE_W     = 16;
  localparam int SEP_W       = 15;
  localparam int THR_W       = 2 * SEP_W;
  localparam int DE_W        = ETA_W + 1;
  localparam int DP_W        = PHI_W + 1;
  localparam int DE_SQ_W     = 2 * DE_W;
  localparam int DP_SQ_W     = 30;
  localparam int PI_FX       = 12868;
  localparam int TWO_PI_FX   = 2 * PI_FX;
  localparam int SEP_RESET   = 3277;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_NONE = '1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               take;
    logic               last;
    logic [IDX_W-1:0]   idx;
  } tts_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tts_qstat_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } tts_result_t;

endpackage

FILE: hdl/tts_front.sv
module tts_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [15:0]       in_ref_eta,
  input  logic signed [14:0]       in_ref_phi,
  input  logic signed [15:0]       in_jet_eta,
  input  logic signed [14:0]       in_jet_phi,
  input  logic [15:0]              in_score,
  input  logic                     in_good,
  input  logic                     in_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [14:0]              cfg_min_separation,
  input  tts_pkg::tts_qstat_t      qstat,
  output logic                     q_push,
  output tts_pkg::tts_item_t       q_item
);
  import tts_pkg::*;

  logic [SEP_W-1:0]         min_sep_r;
  logic [THR_W-1:0]         thr_sq_r;
  logic [THR_W-1:0]         thr_sq_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic                     adv;
  logic                     accept;
  logic                     in_range;

  logic signed [DE_W-1:0]   de_s;
  logic [DE_W-1:0]          de_abs;
  logic signed [DP_W-1:0]   dp_s;
  logic [DP_W-1:0]          dp_abs;
  logic signed [DE_W-1:0]   dp_fold;

  logic                     s1_v_r;
  logic [DE_W-1:0]          s1_de_r;
  logic signed [DE_W-1:0]   s1_dp_r;
  logic [SCORE_W-1:0]       s1_score_r;
  logic                     s1_keep_r;
  logic                     s1_last_r;
  logic [IDX_W-1:0]         s1_idx_r;

  logic [DE_SQ_W-1:0]       de_sq;
  logic signed [DE_SQ_W-1:0] dp_sq_full;

  logic                     s2_v_r;
  logic [DE_SQ_W-1:0]       s2_de_sq_r;
  logic [DP_SQ_W-1:0]       s2_dp_sq_r;
  logic [SCORE_W-1:0]       s2_score_r;
  logic                     s2_keep_r;
  logic                     s2_last_r;
  logic [IDX_W-1:0]         s2_idx_r;

  logic [DE_SQ_W-1:0]       d2;

  assign cfg_ready  = 1'b1;
  assign thr_sq_nxt = min_sep_r * min_sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sep_r <= SEP_W'(SEP_RESET);
      thr_sq_r  <= THR_W'(SEP_RESET * SEP_RESET);
    end else begin
      if (cfg_valid) begin
        min_sep_r <= cfg_min_separation;
      end
      thr_sq_r <= thr_sq_nxt;
    end
  end

  assign adv      = !(s2_v_r && qstat.full);
  assign in_full  = !adv;
  assign accept   = in_push && adv;
  assign in_range = cnt_r < CNT_W'(MAX_JETS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      if (in_last) begin
        cnt_r <= '0;
      end else if (in_range) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign de_s   = DE_W'(in_jet_eta) - DE_W'(in_ref_eta);
  assign de_abs = de_s[DE_W-1] ? DE_W'(-de_s) : DE_W'(de_s);
  assign dp_s   = DP_W'(in_jet_phi) - DP_W'(in_ref_phi);
  assign dp_abs = dp_s[DP_W-1] ? DP_W'(-dp_s) : DP_W'(dp_s);

  always_comb begin
    if (dp_abs >= DP_W'(PI_FX)) begin
      dp_fold = DE_W'(TWO_PI_FX) - DE_W'(dp_abs);
    end else begin
      dp_fold = DE_W'(dp_abs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  assign de_sq      = s1_de_r * s1_de_r;
  assign dp_sq_full = s1_dp_r * s1_dp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_de_r    <= de_abs;
      s1_dp_r    <= dp_fold;
      s1_score_r <= in_score;
      s1_keep_r  <= in_good && in_range;
      s1_last_r  <= in_last;
      s1_idx_r   <= IDX_W'(cnt_r);
      s2_de_sq_r <= de_sq;
      s2_dp_sq_r <= dp_sq_full[DP_SQ_W-1:0];
      s2_score_r <= s1_score_r;
      s2_keep_r  <= s1_keep_r;
      s2_last_r  <= s1_last_r;
      s2_idx_r   <= s1_idx_r;
    end
  end

  assign d2 = s2_de_sq_r + DE_SQ_W'(s2_dp_sq_r);

  assign q_push       = s2_v_r && adv;
  assign q_item.score = s2_score_r;
  assign q_item.take  = s2_keep_r && (d2 > DE_SQ_W'(thr_sq_r));
  assign q_item.last  = s2_last_r;
  assign q_item.idx   = s2_idx_r;

endmodule

FILE: hdl/tts_queue.sv
module tts_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tts_pkg::tts_item_t   item_in,
  input  logic                 pop,
  output tts_pkg::tts_item_t   item_out,
  output tts_pkg::tts_qstat_t  qstat
);
  import tts_pkg::*;

  tts_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign item_out    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty))
    else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/tts_back.sv
module tts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tts_pkg::tts_qstat_t  qstat,
  input  tts_pkg::tts_item_t   q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [4:0]    out_first_index,
  output logic signed [4:0]    out_second_index
);
  import tts_pkg::*;

  logic [SCORE_W-1:0] best_score_r;
  logic [SCORE_W-1:0] run_score_r;
  logic [IDX_W-1:0]   best_slot_r;
  logic [IDX_W-1:0]   run_slot_r;
  logic               best_v_r;
  logic               run_v_r;

  logic [SCORE_W-1:0] best_score_nxt;
  logic [SCORE_W-1:0] run_score_nxt;
  logic [IDX_W-1:0]   best_slot_nxt;
  logic [IDX_W-1:0]   run_slot_nxt;
  logic               best_v_nxt;
  logic               run_v_nxt;

  logic [SCORE_W-1:0] upd_best_score;
  logic [SCORE_W-1:0] upd_run_score;
  logic [IDX_W-1:0]   upd_best_slot;
  logic [IDX_W-1:0]   upd_run_slot;
  logic               upd_best_v;
  logic               upd_run_v;

  logic               gt_best;
  logic               gt_run;

  tts_result_t        ob_mem_r [2];
  logic [1:0]         ob_cnt_r;
  logic               ob_wr_r;
  logic               ob_rd_r;
  logic               ob_full;
  logic               ob_push;
  logic               ob_pop;
  tts_result_t        res;

  assign ob_full   = ob_cnt_r == 2'd2;
  assign out_empty = ob_cnt_r == 2'd0;
  assign q_pop     = !qstat.empty && (!q_item.last || !ob_full);
  assign ob_push   = q_pop && q_item.last;
  assign ob_pop    = out_pop && !out_empty;

  assign gt_best = !best_v_r || (q_item.score > best_score_r);
  assign gt_run  = !run_v_r || (q_item.score > run_score_r);

  always_comb begin
    upd_best_score = best_score_r;
    upd_run_score  = run_score_r;
    upd_best_slot  = best_slot_r;
    upd_run_slot   = run_slot_r;
    upd_best_v     = best_v_r;
    upd_run_v      = run_v_r;
    if (q_pop && q_item.take) begin
      priority if (gt_best) begin
        upd_run_score  = best_score_r;
        upd_run_slot   = best_slot_r;
        upd_run_v      = best_v_r;
        upd_best_score = q_item.score;
        upd_best_slot  = q_item.idx;
        upd_best_v     = 1'b1;
      end else if (gt_run) begin
        upd_run_score = q_item.score;
        upd_run_slot  = q_item.idx;
        upd_run_v     = 1'b1;
      end
    end
    res.first_index  = upd_best_slot;
    res.second_index = upd_run_slot;
    best_score_nxt = upd_best_score;
    run_score_nxt  = upd_run_score;
    if (ob_push) begin
      best_slot_nxt = IDX_NONE;
      run_slot_nxt  = IDX_NONE;
      best_v_nxt    = 1'b0;
      run_v_nxt     = 1'b0;
    end else begin
      best_slot_nxt = upd_best_slot;
      run_slot_nxt  = upd_run_slot;
      best_v_nxt    = upd_best_v;
      run_v_nxt     = upd_run_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_slot_r <= IDX_NONE;
      run_slot_r  <= IDX_NONE;
      best_v_r    <= 1'b0;
      run_v_r     <= 1'b0;
    end else begin
      best_slot_r <= best_slot_nxt;
      run_slot_r  <= run_slot_nxt;
      best_v_r    <= best_v_nxt;
      run_v_r     <= run_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_score_r <= best_score_nxt;
    run_score_r  <= run_score_nxt;
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_mem_r[ob_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= '0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
    end else begin
      if (ob_push) begin
        ob_wr_r <= !ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= !ob_rd_r;
      end
      if (ob_push && !ob_pop) begin
        ob_cnt_r <= ob_cnt_r + 1'b1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt_r <= ob_cnt_r - 1'b1;
      end
    end
  end

  assign out_first_index  = ob_mem_r[ob_rd_r].first_index;
  assign out_second_index = ob_mem_r[ob_rd_r].second_index;

`ifndef SYNTHESIS
  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2)
    else $error("result buffer count beyond depth");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |=> !best_v_r && !run_v_r && best_slot_r == IDX_NONE)
    else $error("selection not cleared after last beat");
  a_run_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    run_v_r |-> best_v_r && (run_score_r <= best_score_r))
    else $error("runner-up held without a better best");
`endif

endmodule

FILE: hdl/top_two_score_with_separation_veto_unit.sv
// Channel  Direction  Handshake            Beat
// in_      input      in_push / in_full    ref/jet eta and phi, score, good, last
// out_     output     out_empty / out_pop  first_index, second_index
// cfg_     input      cfg_valid/cfg_ready  min_separation
//
// One input beat per cycle while in_full is low; a result passes s1, s2, queue and buffer.
// Front pipeline: difference and phi fold, two squares, threshold compare into a 4-deep queue.
// Back: one top-two update per cycle unless a last jet meets a full 2-entry result buffer.
// rst_n is synchronous; in_full rises only when the queue is full behind a stalled output.
module top_two_score_with_separation_veto_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_ref_eta,
  input  logic signed [14:0] in_ref_phi,
  input  logic signed [15:0] in_jet_eta,
  input  logic signed [14:0] in_jet_phi,
  input  logic [15:0]        in_score,
  input  logic               in_good,
  input  logic               in_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [4:0]  out_first_index,
  output logic signed [4:0]  out_second_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_min_separation
);
  import tts_pkg::*;

  tts_qstat_t qstat;
  tts_item_t  push_item;
  tts_item_t  head_item;
  logic       q_push;
  logic       q_pop;

  tts_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_ref_eta         (in_ref_eta),
    .in_ref_phi         (in_ref_phi),
    .in_jet_eta         (in_jet_eta),
    .in_jet_phi         (in_jet_phi),
    .in_score           (in_score),
    .in_good            (in_good),
    .in_last            (in_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_min_separation (cfg_min_separation),
    .qstat              (qstat),
    .q_push             (q_push),
    .q_item             (push_item)
  );

  tts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (push_item),
    .pop      (q_pop),
    .item_out (head_item),
    .qstat    (qstat)
  );

  tts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .qstat            (qstat),
    .q_item           (head_item),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index)
  );

endmodule

FILE: sim/top_two_score_with_separation_veto_unit_test.sv
module top_two_score_with_separation_veto_unit_test;
  import tts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_HOLD      = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [15:0] in_ref_eta;
  logic signed [14:0] in_ref_phi;
  logic signed [15:0] in_jet_eta;
  logic signed [14:0] in_jet_phi;
  logic [15:0]        in_score;
  logic               in_good;
  logic               in_last;
  logic               out_empty;
  logic               out_pop;
  logic signed [4:0]  out_first_index;
  logic signed [4:0]  out_second_index;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [14:0]        cfg_min_separation;

  int sel_min_sep      = SEP_RESET;
  int sel_jet_count    = 0;
  int sel_best_score   = -1;
  int sel_runner_score = -1;
  int sel_best_slot    = -1;
  int sel_runner_slot  = -1;

  tts_result_t expected_picks[$];
  tts_result_t head_pick;

  int error_count    = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold_left   = 0;

  top_two_score_with_separation_veto_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_ref_eta         (in_ref_eta),
    .in_ref_phi         (in_ref_phi),
    .in_jet_eta         (in_jet_eta),
    .in_jet_phi         (in_jet_phi),
    .in_score           (in_score),
    .in_good            (in_good),
    .in_last            (in_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_first_index    (out_first_index),
    .out_second_index   (out_second_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_min_separation (cfg_min_separation)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_selection();
    sel_jet_count    = 0;
    sel_best_score   = -1;
    sel_runner_score = -1;
    sel_best_slot    = -1;
    sel_runner_slot  = -1;
  endfunction

  function automatic void update_top_two(input logic signed [15:0] reta,
                                         input logic signed [14:0] rphi,
                                         input logic signed [15:0] jeta,
                                         input logic signed [14:0] jphi,
                                         input logic [15:0] sc,
                                         input logic good, input logic last);
    int          d_eta;
    int          d_phi;
    int          score_v;
    longint      dist_sq;
    longint      thr_sq;
    tts_result_t pick;
    if (sel_jet_count < MAX_JETS) begin
      d_eta = int'(jeta) - int'(reta);
      d_phi = int'(jphi) - int'(rphi);
      if (d_eta < 0) d_eta = -d_eta;
      if (d_phi < 0) d_phi = -d_phi;
      if (d_phi >= PI_FX) d_phi = TWO_PI_FX - d_phi;
      dist_sq = longint'(d_eta) * d_eta + longint'(d_phi) * d_phi;
      thr_sq  = longint'(sel_min_sep) * sel_min_sep;
      score_v = int'(sc);
      if (good && dist_sq > thr_sq) begin
        if (score_v > sel_best_score) begin
          sel_runner_score = sel_best_score;
          sel_runner_slot  = sel_best_slot;
          sel_best_score   = score_v;
          sel_best_slot    = sel_jet_count;
        end else if (score_v > sel_runner_score) begin
          sel_runner_score = score_v;
          sel_runner_slot  = sel_jet_count;
        end
      end
      sel_jet_count++;
    end
    if (last) begin
      pick.first_index  = sel_best_slot[IDX_W-1:0];
      pick.second_index = sel_runner_slot[IDX_W-1:0];
      expected_picks = {expected_picks, pick};
      clear_selection();
    end
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_picks.size() == 0) begin
          log_error($sformatf("unexpected result beat first=%0d second=%0d",
                              out_first_index, out_second_index));
        end else begin
          head_pick = expected_picks.pop_front();
          if (out_first_index !== head_pick.first_index)
            log_error($sformatf("first_index mismatch: expected %0d actual %0d",
                                $signed(head_pick.first_index), out_first_index));
          if (out_second_index !== head_pick.second_index)
            log_error($sformatf("second_index mismatch: expected %0d actual %0d",
                                $signed(head_pick.second_index), out_second_index));
        end
      end
      if (in_push && !in_full)
        update_top_two(in_ref_eta, in_ref_phi, in_jet_eta, in_jet_phi,
                       in_score, in_good, in_last);
      if (cfg_valid && cfg_ready)
        sel_min_sep = int'(cfg_min_separation);
    end
  end

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_pop <= 1'b0;
      rx_hold_left--;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_jet(input logic signed [15:0] reta, input logic signed [14:0] rphi,
                          input logic signed [15:0] jeta, input logic signed [14:0] jphi,
                          input logic [15:0] sc, input logic good, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push    <= 1'b1;
    in_ref_eta <= reta;
    in_ref_phi <= rphi;
    in_jet_eta <= jeta;
    in_jet_phi <= jphi;
    in_score   <= sc;
    in_good    <= good;
    in_last    <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_min_separation(input logic [14:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_min_separation <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [14:0] pick_phi();
    case ($urandom_range(7))
      0:       return 15'($urandom);
      1:       return ($urandom_range(1) != 0) ? 15'(PI_FX) : -15'(PI_FX);
      default: return 15'(int'($urandom_range(TWO_PI_FX)) - PI_FX);
    endcase
  endfunction

  function automatic logic [15:0] pick_score();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd30000;
      3:       return 16'd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_event(input int n_jets);
    logic signed [15:0] reta;
    logic signed [15:0] jeta;
    logic signed [14:0] rphi;
    reta = 16'($urandom);
    rphi = pick_phi();
    for (int j = 0; j < n_jets; j++) begin
      if ($urandom_range(9) == 0) begin
        reta = 16'($urandom);
        rphi = pick_phi();
      end
      if ($urandom_range(2) == 0) jeta = 16'($urandom);
      else jeta = reta + 16'($urandom_range(8000)) - 16'd4000;
      send_jet(reta, rphi, jeta, pick_phi(), pick_score(), $urandom_range(99) < 85,
               (j == n_jets - 1) && ($urandom_range(19) != 0));
    end
  endtask

  task automatic test_directed_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_jet(16'sd0, 15'sd0, 16'sd20000, 15'sd0, 16'd500, 1'b0, 1'b1);
    send_jet(16'sd0, 15'sd0, 16'sd20000, 15'sd0, 16'hFFFF, 1'b1, 1'b1);
    // tie goes to second place; distance equal to threshold is vetoed
    send_jet(16'sd0, 15'sd0, 16'sd20000, 15'sd0, 16'd100, 1'b1, 1'b0);
    send_jet(16'sd0, 15'sd0, 16'sd20000, 15'sd0, 16'd100, 1'b1, 1'b0);
    send_jet(16'sd0, 15'sd0, 16'sd20000, 15'sd0, 16'd0, 1'b1, 1'b0);
    send_jet(16'sd0, 15'sd0, 16'sd3277, 15'sd0, 16'd200, 1'b1, 1'b0);
    send_jet(16'sd0, 15'sd0, 16'sd3278, 15'sd0, 16'd150, 1'b1, 1'b1);
    // fold at pi, phi beyond pi, eta extremes
    send_jet(16'sd0, 15'sd12868, 16'sd0, -15'sd12868, 16'd500, 1'b1, 1'b0);
    send_jet(16'sd0, -15'sd16384, 16'sd0, 15'sd16383, 16'd400, 1'b1, 1'b0);
    send_jet(-16'sd32768, 15'sd0, 16'sd32767, 15'sd0, 16'd300, 1'b1, 1'b1);
    // jets past the maximum count are dropped
    for (int j = 0; j <= MAX_JETS; j++)
      send_jet(16'sd0, 15'sd0, -16'sd20000, 15'sd100,
               (j == MAX_JETS) ? 16'hFFFF : 16'(j * 100), 1'b1, j == MAX_JETS);
  endtask

  task automatic test_random_events(input int n_items, input int idle_pct,
                                    input int stall_pct);
    int sent;
    int n_jets;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      n_jets = ($urandom_range(9) == 0) ? $urandom_range(MAX_JETS + 1, MAX_JETS + 4)
                                        : $urandom_range(1, 12);
      send_random_event(n_jets);
      sent += n_jets;
    end
  endtask

  task automatic test_full_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_left   = LONG_HOLD;
    for (int j = 0; j < 40; j++)
      send_jet(16'($urandom), pick_phi(), 16'($urandom), pick_phi(), pick_score(),
               $urandom_range(99) < 85, $urandom_range(3) != 0);
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    for (int k = 0; k < 3; k++) begin
      send_random_event($urandom_range(1, 5));
      drain_results();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_push            = 1'b0;
    in_ref_eta         = '0;
    in_ref_phi         = '0;
    in_jet_eta         = '0;
    in_jet_phi         = '0;
    in_score           = '0;
    in_good            = 1'b0;
    in_last            = 1'b0;
    out_pop            = 1'b0;
    cfg_valid          = 1'b0;
    cfg_min_separation = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    set_min_separation(15'd0);
    test_random_events(320, 0, 0);
    set_min_separation(15'h7FFF);
    test_random_events(320, 82, 0);
    set_min_separation(15'(SEP_RESET));
    test_random_events(320, 0, 82);
    set_min_separation(15'($urandom_range(12000)));
    test_random_events(320, 9, 9);
    test_full_backpressure();
    test_drain_pause();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_picks.size() != 0)
      log_error($sformatf("%0d results never arrived", expected_picks.size()));
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tts_pkg.sv
hdl/tts_front.sv
hdl/tts_queue.sv
hdl/tts_back.sv
hdl/top_two_score_with_separation_veto_unit.sv
sim/top_two_score_with_separation_veto_unit_test.sv
